// File: src/dcs_pkg.sv
// Shared constants for the DDS command serializer: command codes, register
// addresses, frame lengths and divider constants. No dependencies.
package dcs_pkg;

  localparam int unsigned CmdW   = 3;
  localparam int unsigned MaskW  = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned Fr1W   = 24;
  localparam int unsigned Fr2W   = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;

  // Command codes
  localparam logic [CmdW-1:0] CmdFreq   = 3'd0;
  localparam logic [CmdW-1:0] CmdAmpl   = 3'd1;
  localparam logic [CmdW-1:0] CmdPhWord = 3'd2;
  localparam logic [CmdW-1:0] CmdPhDeg  = 3'd3;
  localparam logic [CmdW-1:0] CmdUpdate = 3'd4;
  localparam logic [CmdW-1:0] CmdInit   = 3'd5;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgFr1 = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFr2 = 2'd1;

  // Chip register addresses
  localparam logic [7:0] AddrCsr   = 8'h00;
  localparam logic [7:0] AddrFr1   = 8'h01;
  localparam logic [7:0] AddrFr2   = 8'h02;
  localparam logic [7:0] AddrCftw0 = 8'h04;
  localparam logic [7:0] AddrCpow0 = 8'h05;
  localparam logic [7:0] AddrAcr   = 8'h06;

  // Frame shifter: address byte plus up to four data bytes, left aligned
  localparam int unsigned FrameW = 40;
  localparam int unsigned LenW   = 6;
  localparam logic [LenW-1:0] Len2Byte = 6'd16;
  localparam logic [LenW-1:0] Len3Byte = 6'd24;
  localparam logic [LenW-1:0] Len4Byte = 6'd32;
  localparam logic [LenW-1:0] Len5Byte = 6'd40;

  // Serial divider
  localparam int unsigned NumW  = 64;
  localparam int unsigned RemW  = 29;
  localparam int unsigned QuoW  = 32;
  localparam int unsigned DcntW = 7;
  localparam logic [RemW:0]    SysclkHz  = 30'd500000000;
  localparam logic [RemW:0]    DegFull   = 30'd360;
  localparam logic [13:0]      DegBias   = 14'd180;
  localparam logic [DcntW-1:0] StepsFreq = 7'd64;
  localparam logic [DcntW-1:0] StepsMod  = 7'd16;
  localparam logic [DcntW-1:0] StepsDeg  = 7'd23;

  // Divider job kinds
  localparam logic [1:0] DivFreq = 2'd0;
  localparam logic [1:0] DivMod  = 2'd1;
  localparam logic [1:0] DivDeg  = 2'd2;

endpackage

// File: src/dds_command_spi_serializer_core.sv
// DDS command serializer top level: turns one command into serial write
// frames, one output transfer per bit. Depends on dcs_pkg.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------------
//   in      | sink      | in_valid_i/in_stall_o  | command_i, channel_mask_i, value_i
//   out     | source    | out_valid_o/out_stall_i| data_bit_o, frame_start_o,
//           |           |                        | frame_end_o, update_strobe_o,
//           |           |                        | reset_strobe_o, last_o
//   cfg     | sink      | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One command at a time. Each output transfer is one cycle when not stalled:
// amplitude 48, phase word 40, update 1, init 57 transfers. Frequency runs
// a bit-serial divide (tuning word) ahead of its 56 transfers; phase in
// degrees runs a divide mod 360, then a scaling divide, ahead of 40
// transfers. The divider yields one quotient bit per cycle. Reset clears
// control and loads the FR1/FR2 reset words. A stalled output holds its
// transfer; the sequencer waits behind it, and a new command is taken
// while the final transfer still waits in the output.
module dds_command_spi_serializer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [dcs_pkg::CmdW-1:0]    command_i,
  input  logic [dcs_pkg::MaskW-1:0]   channel_mask_i,
  input  logic [dcs_pkg::ValueW-1:0]  value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        data_bit_o,
  output logic                        frame_start_o,
  output logic                        frame_end_o,
  output logic                        update_strobe_o,
  output logic                        reset_strobe_o,
  output logic                        last_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dcs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dcs_pkg::CfgDataW-1:0] cfg_data_i
);
  import dcs_pkg::*;

  // Sequencer states
  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SDiv   = 3'd1;
  localparam logic [2:0] SPulse = 3'd2;
  localparam logic [2:0] SFrmA  = 3'd3;
  localparam logic [2:0] SFrmB  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [Fr1W-1:0]   fr1_q;
  logic [Fr2W-1:0]   fr2_q;

  // Frame shifter and pending second frame
  logic [FrameW-1:0] sr_q, sr_d;
  logic [LenW-1:0]   cnt_q, cnt_d;
  logic              first_q, first_d;
  logic [FrameW-1:0] frm_b_q, frm_b_d;
  logic [LenW-1:0]   len_b_q, len_b_d;
  logic              pulse_rst_q, pulse_rst_d;

  // Bit-serial restoring divider
  logic [NumW-1:0]   num_q, num_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [QuoW-1:0]   quo_q, quo_d;
  logic [DcntW-1:0]  dcnt_q, dcnt_d;
  logic [1:0]        djob_q, djob_d;
  logic [RemW:0]     divisor;
  logic [RemW:0]     rem_shift;
  logic              rem_ge;
  logic [RemW:0]     rem_sub;
  logic [RemW-1:0]   rem_next;
  logic [QuoW-1:0]   quo_next;

  // Output register
  logic out_valid_q, out_valid_d;
  logic data_bit_q, frame_start_q, frame_end_q, upd_q, rst_q, last_q;
  logic gen_valid, gen_bit, gen_fs, gen_fe, gen_upd, gen_rst, gen_last;
  logic adv;
  logic in_take;

  assign in_stall_o  = (state_q != SIdle);
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign adv         = !out_valid_q || !out_stall_i;

  // One divide step: bring in the next dividend bit, subtract if it fits
  assign divisor   = (djob_q == DivFreq) ? SysclkHz : DegFull;
  assign rem_shift = {rem_q, num_q[NumW-1]};
  assign rem_ge    = (rem_shift >= divisor);
  assign rem_sub   = rem_shift - divisor;
  assign rem_next  = rem_ge ? rem_sub[RemW-1:0] : rem_shift[RemW-1:0];
  assign quo_next  = {quo_q[QuoW-2:0], rem_ge};

  always_comb begin
    state_d     = state_q;
    sr_d        = sr_q;
    cnt_d       = cnt_q;
    first_d     = first_q;
    frm_b_d     = frm_b_q;
    len_b_d     = len_b_q;
    pulse_rst_d = pulse_rst_q;
    num_d       = num_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dcnt_d      = dcnt_q;
    djob_d      = djob_q;
    gen_valid   = 1'b0;
    gen_bit     = 1'b0;
    gen_fs      = 1'b0;
    gen_fe      = 1'b0;
    gen_upd     = 1'b0;
    gen_rst     = 1'b0;
    gen_last    = 1'b0;

    unique case (state_q)
      SIdle: begin
        if (in_take) begin
          // The channel-select frame opens every value command
          sr_d    = {AddrCsr, channel_mask_i, 24'h000000};
          cnt_d   = Len2Byte;
          first_d = 1'b1;
          rem_d   = '0;
          case (command_i)
            CmdFreq: begin
              num_d   = {value_i, 32'h00000000};
              dcnt_d  = StepsFreq;
              djob_d  = DivFreq;
              state_d = SDiv;
            end
            CmdAmpl: begin
              frm_b_d = {AddrAcr, 8'h00, 6'b000100, value_i[9:0], 8'h00};
              len_b_d = Len4Byte;
              state_d = SFrmA;
            end
            CmdPhWord: begin
              frm_b_d = {AddrCpow0, 2'b00, value_i[13:0], 16'h0000};
              len_b_d = Len3Byte;
              state_d = SFrmA;
            end
            CmdPhDeg: begin
              num_d   = {value_i[15:0], 48'h0};
              dcnt_d  = StepsMod;
              djob_d  = DivMod;
              state_d = SDiv;
            end
            CmdUpdate: begin
              pulse_rst_d = 1'b0;
              state_d     = SPulse;
            end
            CmdInit: begin
              pulse_rst_d = 1'b1;
              sr_d        = {AddrFr1, fr1_q, 8'h00};
              cnt_d       = Len4Byte;
              frm_b_d     = {AddrFr2, fr2_q, 16'h0000};
              len_b_d     = Len3Byte;
              state_d     = SPulse;
            end
            default: begin
              // Unused codes: drop the command, no transfers
              state_d = SIdle;
            end
          endcase
        end
      end
      SDiv: begin
        num_d  = {num_q[NumW-2:0], 1'b0};
        rem_d  = rem_next;
        quo_d  = quo_next;
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == 7'd1) begin
          case (djob_q)
            DivFreq: begin
              frm_b_d = {AddrCftw0, quo_next};
              len_b_d = Len5Byte;
              state_d = SFrmA;
            end
            DivMod: begin
              // Remainder is degrees mod 360; scale it: (d*16384 + 180) / 360
              num_d  = {rem_next[8:0], DegBias, 41'h0};
              rem_d  = '0;
              dcnt_d = StepsDeg;
              djob_d = DivDeg;
            end
            default: begin
              frm_b_d = {AddrCpow0, 2'b00, quo_next[13:0], 16'h0000};
              len_b_d = Len3Byte;
              state_d = SFrmA;
            end
          endcase
        end
      end
      SPulse: begin
        gen_valid = 1'b1;
        gen_upd   = !pulse_rst_q;
        gen_rst   = pulse_rst_q;
        gen_last  = !pulse_rst_q;
        if (adv) begin
          state_d = pulse_rst_q ? SFrmA : SIdle;
        end
      end
      SFrmA, SFrmB: begin
        gen_valid = 1'b1;
        gen_bit   = sr_q[FrameW-1];
        gen_fs    = first_q;
        gen_fe    = (cnt_q == 6'd1);
        gen_last  = (cnt_q == 6'd1) && (state_q == SFrmB);
        if (adv) begin
          sr_d    = {sr_q[FrameW-2:0], 1'b0};
          cnt_d   = cnt_q - 1'b1;
          first_d = 1'b0;
          if (cnt_q == 6'd1) begin
            if (state_q == SFrmA) begin
              // Advance to the value frame
              sr_d    = frm_b_q;
              cnt_d   = len_b_q;
              first_d = 1'b1;
              state_d = SFrmB;
            end else begin
              state_d = SIdle;
            end
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  assign out_valid_d = adv ? gen_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
      fr1_q       <= 24'hD00000;
      fr2_q       <= 16'h0000;
      cnt_q       <= '0;
      dcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      dcnt_q      <= dcnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgFr1) begin
          fr1_q <= cfg_data_i[Fr1W-1:0];
        end else if (cfg_index_i == CfgFr2) begin
          fr2_q <= cfg_data_i[Fr2W-1:0];
        end
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk_i) begin
    sr_q        <= sr_d;
    first_q     <= first_d;
    frm_b_q     <= frm_b_d;
    len_b_q     <= len_b_d;
    pulse_rst_q <= pulse_rst_d;
    num_q       <= num_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    djob_q      <= djob_d;
    if (adv && gen_valid) begin
      data_bit_q    <= gen_bit;
      frame_start_q <= gen_fs;
      frame_end_q   <= gen_fe;
      upd_q         <= gen_upd;
      rst_q         <= gen_rst;
      last_q        <= gen_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign data_bit_o      = data_bit_q;
  assign frame_start_o   = frame_start_q;
  assign frame_end_o     = frame_end_q;
  assign update_strobe_o = upd_q;
  assign reset_strobe_o  = rst_q;
  assign last_o          = last_q;

  a_div_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDiv) |-> (dcnt_q != 7'd0))
    else $error("divider running with zero step count");

  a_frame_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SFrmA || state_q == SFrmB) |-> (cnt_q != 6'd0))
    else $error("frame shifter running with zero bit count");

  a_last_frame_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SFrmB && adv && cnt_q == 6'd1) |=> (state_q == SIdle))
    else $error("sequencer did not return to idle after the final bit");

  a_pulse_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (upd_q || rst_q)) |->
      (!data_bit_q && !frame_start_q && !frame_end_q && !(upd_q && rst_q)))
    else $error("pulse transfer carries frame bits");

endmodule
